>>> src/bst_pkg.sv
// Shared types and constants for the bounded sequence table.
`default_nettype none

package bst_pkg;

   // Field widths of the request and response transactions.
   localparam int ACTION_W   = 3;
   localparam int POSITION_W = 9;
   localparam int VALUE_W    = 32;
   localparam int STATUS_W   = 2;
   localparam int INDEX_W    = 9;
   localparam int COUNT_W    = 9;

   // Packed bus widths, rounded up to whole bytes.
   localparam int REQ_DATA_W = 48;
   localparam int RSP_DATA_W = 56;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT_AT     = 3'd0,
      ACT_INSERT_SORTED = 3'd1,
      ACT_ERASE_AT      = 3'd2,
      ACT_REMOVE_ALL    = 3'd3,
      ACT_GET           = 3'd4,
      ACT_SET           = 3'd5,
      ACT_FIND          = 3'd6
   } action_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_BAD_POS   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_SCAN = 2'd1,
      S_GET  = 2'd2,
      S_DONE = 2'd3
   } state_type;

endpackage

`default_nettype wire

>>> src/bst_ram.sv
// Generic simple dual-port RAM with one write port and one registered read port.
`default_nettype none

module bst_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

>>> src/bounded_sequence_table_core.sv
// Top level of the bounded sequence table: an ordered list held in one RAM.
//
// The block keeps an ordered list of up to DEPTH items and a count. Each request
// transaction gets exactly one response transaction. Set, the unused action code
// and any request rejected up front go from acceptance straight to the done state,
// which loads the response register; get first reads the item RAM in its own state.
// Insert, sorted insert, erase, remove-all and find walk the held items one entry
// per cycle through the single read port of the item RAM, from their start index
// up to the count; find stops at its first match. One request is worked on at a
// time; a new request is taken while the previous response still waits in the
// output register. The RAM is not cleared after reset and needs no clearing pass:
// only entries below the count are read.
`default_nettype none

module bounded_sequence_table_core #(
   parameter int DEPTH      = 256,
   parameter int ITEM_WIDTH = 32
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   // [2:0] action, [11:3] position, [43:12] item_value, [47:44] zero
   input  wire logic [bst_pkg::REQ_DATA_W-1:0] req_tdata,
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // [1:0] status, [10:2] index_or_count, [42:11] read_value, [51:43] item_count,
   // [55:52] zero
   output logic      [bst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int XW = (CW > bst_pkg::POSITION_W) ? CW : bst_pkg::POSITION_W;

   bst_pkg::state_type  state_ff, state_in;
   bst_pkg::action_type act_ff, act_in;
   bst_pkg::status_type sts_ff, sts_in;
   logic [ITEM_WIDTH-1:0] val_ff, val_in;
   logic [ITEM_WIDTH-1:0] carry_ff, carry_in;
   logic [ITEM_WIDTH-1:0] rdv_ff, rdv_in;
   logic                  found_ff, found_in;
   logic                  pend_ff, pend_in;
   logic [CW-1:0]         rd_k_ff, rd_k_in;
   logic [CW-1:0]         dk_ff, dk_in;
   logic [CW-1:0]         wr_ptr_ff, wr_ptr_in;
   logic [CW-1:0]         cnt_ff, cnt_in;
   logic [CW-1:0]         idx_ff, idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [bst_pkg::RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;

   // Request decode
   logic                  accept;
   bst_pkg::action_type   req_act;
   logic [XW-1:0]         req_pos_x;
   logic [63:0]           req_val_x;
   logic [ITEM_WIDTH-1:0] req_val;
   logic [XW-1:0]         cnt_x;
   logic                  is_full;
   bst_pkg::status_type   req_sts;

   // Scan control
   logic more;
   logic hit;
   logic scan_end;
   logic out_free;

   // RAM port signals
   logic                  wr_en;
   logic [AW-1:0]         wr_addr;
   logic [ITEM_WIDTH-1:0] wr_data;
   logic                  rd_en;
   logic [AW-1:0]         rd_addr;
   logic [ITEM_WIDTH-1:0] rd_data;

   // Response packing
   logic [XW-1:0] idx_x;
   logic [63:0]   rdv_x;

   bst_ram #(
      .WIDTH (ITEM_WIDTH),
      .DEPTH (DEPTH)
   ) u_item_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == bst_pkg::S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign req_act    = bst_pkg::action_type'(req_tdata[2:0]);
   assign req_pos_x  = XW'(req_tdata[11:3]);
   assign req_val_x  = 64'(req_tdata[43:12]);
   assign req_val    = req_val_x[ITEM_WIDTH-1:0];
   assign cnt_x      = XW'(cnt_ff);
   assign is_full    = (cnt_ff == CW'(DEPTH));

   assign more     = (rd_k_ff < cnt_ff);
   assign hit      = pend_ff && (rd_data == val_ff);
   assign scan_end = !pend_ff && !more;
   assign out_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign idx_x = XW'(idx_ff);
   assign rdv_x = 64'(rdv_ff);

   // Up-front rejection of a request; position checks precede the full check.
   always_comb begin
      req_sts = bst_pkg::ST_OK;
      case (req_act)
         bst_pkg::ACT_INSERT_AT: begin
            if (req_pos_x > cnt_x) begin
               req_sts = bst_pkg::ST_BAD_POS;
            end else if (is_full) begin
               req_sts = bst_pkg::ST_FULL;
            end
         end
         bst_pkg::ACT_INSERT_SORTED: begin
            if (is_full) begin
               req_sts = bst_pkg::ST_FULL;
            end
         end
         bst_pkg::ACT_ERASE_AT, bst_pkg::ACT_GET, bst_pkg::ACT_SET: begin
            if (req_pos_x >= cnt_x) begin
               req_sts = bst_pkg::ST_BAD_POS;
            end
         end
         default: begin
            req_sts = bst_pkg::ST_OK;
         end
      endcase
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bst_pkg::S_IDLE: begin
            if (accept) begin
               if (req_sts != bst_pkg::ST_OK) begin
                  state_in = bst_pkg::S_DONE;
               end else begin
                  case (req_act)
                     bst_pkg::ACT_INSERT_AT, bst_pkg::ACT_INSERT_SORTED,
                     bst_pkg::ACT_ERASE_AT, bst_pkg::ACT_REMOVE_ALL,
                     bst_pkg::ACT_FIND: begin
                        state_in = bst_pkg::S_SCAN;
                     end
                     bst_pkg::ACT_GET: begin
                        state_in = bst_pkg::S_GET;
                     end
                     default: begin
                        state_in = bst_pkg::S_DONE;
                     end
                  endcase
               end
            end
         end
         bst_pkg::S_SCAN: begin
            if (scan_end || (act_ff == bst_pkg::ACT_FIND && hit)) begin
               state_in = bst_pkg::S_DONE;
            end
         end
         bst_pkg::S_GET: begin
            state_in = bst_pkg::S_DONE;
         end
         bst_pkg::S_DONE: begin
            if (out_free) begin
               state_in = bst_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = bst_pkg::S_IDLE;
         end
      endcase
   end

   // Datapath and RAM control
   always_comb begin
      act_in       = act_ff;
      sts_in       = sts_ff;
      val_in       = val_ff;
      carry_in     = carry_ff;
      rdv_in       = rdv_ff;
      found_in     = found_ff;
      pend_in      = pend_ff;
      rd_k_in      = rd_k_ff;
      dk_in        = dk_ff;
      wr_ptr_in    = wr_ptr_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = '0;
      wr_data      = '0;
      rd_en        = 1'b0;
      rd_addr      = '0;

      case (state_ff)
         bst_pkg::S_IDLE: begin
            if (accept) begin
               act_in    = req_act;
               val_in    = req_val;
               carry_in  = req_val;
               sts_in    = req_sts;
               idx_in    = '0;
               rdv_in    = '0;
               pend_in   = 1'b0;
               found_in  = 1'b1;
               rd_k_in   = '0;
               wr_ptr_in = '0;
               if (req_sts == bst_pkg::ST_OK) begin
                  case (req_act)
                     bst_pkg::ACT_INSERT_AT: begin
                        rd_k_in = CW'(req_pos_x);
                     end
                     bst_pkg::ACT_INSERT_SORTED: begin
                        found_in = 1'b0;
                     end
                     bst_pkg::ACT_ERASE_AT: begin
                        rd_k_in   = CW'(req_pos_x + XW'(1));
                        wr_ptr_in = CW'(req_pos_x);
                     end
                     bst_pkg::ACT_GET: begin
                        rd_en   = 1'b1;
                        rd_addr = AW'(req_pos_x);
                     end
                     bst_pkg::ACT_SET: begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(req_pos_x);
                        wr_data = req_val;
                     end
                     bst_pkg::ACT_FIND: begin
                        sts_in = bst_pkg::ST_NOT_FOUND;
                     end
                     default: begin
                        rd_k_in = '0;
                     end
                  endcase
               end
            end
         end
         bst_pkg::S_SCAN: begin
            // Issue the next read while the previous entry's data comes back.
            if (more && !(act_ff == bst_pkg::ACT_FIND && hit)) begin
               rd_en   = 1'b1;
               rd_addr = rd_k_ff[AW-1:0];
               rd_k_in = rd_k_ff + CW'(1);
               dk_in   = rd_k_ff;
               pend_in = 1'b1;
            end else begin
               pend_in = 1'b0;
            end

            if (pend_ff) begin
               case (act_ff)
                  bst_pkg::ACT_INSERT_AT, bst_pkg::ACT_INSERT_SORTED: begin
                     // Once the insert point is passed, each entry moves up one
                     // place by writing the carried item and carrying the old one.
                     if (found_ff || rd_data >= val_ff) begin
                        wr_en    = 1'b1;
                        wr_addr  = dk_ff[AW-1:0];
                        wr_data  = carry_ff;
                        carry_in = rd_data;
                        if (!found_ff) begin
                           found_in = 1'b1;
                           idx_in   = dk_ff;
                        end
                     end
                  end
                  bst_pkg::ACT_ERASE_AT, bst_pkg::ACT_REMOVE_ALL: begin
                     // Compaction: the write pointer never passes the read index.
                     if (act_ff == bst_pkg::ACT_ERASE_AT || rd_data != val_ff) begin
                        wr_en     = 1'b1;
                        wr_addr   = wr_ptr_ff[AW-1:0];
                        wr_data   = rd_data;
                        wr_ptr_in = wr_ptr_ff + CW'(1);
                     end
                  end
                  bst_pkg::ACT_FIND: begin
                     if (hit) begin
                        sts_in = bst_pkg::ST_OK;
                        idx_in = dk_ff;
                     end
                  end
                  default: begin
                     pend_in = 1'b0;
                  end
               endcase
            end

            if (scan_end) begin
               case (act_ff)
                  bst_pkg::ACT_INSERT_AT, bst_pkg::ACT_INSERT_SORTED: begin
                     wr_en   = 1'b1;
                     wr_addr = cnt_ff[AW-1:0];
                     wr_data = carry_ff;
                     cnt_in  = cnt_ff + CW'(1);
                     if (!found_ff) begin
                        idx_in = cnt_ff;
                     end
                  end
                  bst_pkg::ACT_ERASE_AT: begin
                     cnt_in = wr_ptr_ff;
                  end
                  bst_pkg::ACT_REMOVE_ALL: begin
                     cnt_in = wr_ptr_ff;
                     idx_in = cnt_ff - wr_ptr_ff;
                  end
                  default: begin
                     cnt_in = cnt_ff;
                  end
               endcase
            end
         end
         bst_pkg::S_GET: begin
            rdv_in = rd_data;
         end
         bst_pkg::S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {4'b0, cnt_x[bst_pkg::COUNT_W-1:0], rdv_x[bst_pkg::VALUE_W-1:0],
                               idx_x[bst_pkg::INDEX_W-1:0], sts_ff};
            end
         end
         default: begin
            pend_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= bst_pkg::S_IDLE;
         cnt_ff       <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      sts_ff      <= sts_in;
      val_ff      <= val_in;
      carry_ff    <= carry_in;
      rdv_ff      <= rdv_in;
      found_ff    <= found_in;
      rd_k_ff     <= rd_k_in;
      dk_ff       <= dk_in;
      wr_ptr_ff   <= wr_ptr_in;
      idx_ff      <= idx_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

>>> src/bst_checker.sv
// Port-level checker for the bounded sequence table, bound to its top level.
`default_nettype none

module bst_checker (
   input wire logic                           clock,
   input wire logic                           reset,
   input wire logic                           req_tvalid,
   input wire logic                           req_tready,
   input wire logic                           rsp_tvalid,
   input wire logic                           rsp_tready,
   input wire logic [bst_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   logic       req_acc;
   logic       rsp_acc;
   logic [1:0] open_ff, open_in;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // Number of request transactions not yet answered.
   always_comb begin
      open_in = open_ff;
      if (req_acc && !rsp_acc) begin
         open_in = open_ff + 2'd1;
      end else if (rsp_acc && !req_acc) begin
         open_in = open_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         open_ff <= '0;
      end else begin
         open_ff <= open_in;
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("response changed while stalled");

   a_rsp_has_req: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> open_ff != 2'd0)
      else $error("response without an open request");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      open_ff == 2'd2 |-> !req_tready)
      else $error("request taken while one is in work and one waits");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      open_ff != 2'd3)
      else $error("more than two requests open");

endmodule

bind bounded_sequence_table_core bst_checker u_bst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
